// File: rtl/vpv_pkg.sv
// Shared constants, payload types and helper functions for the vertex projection block.
`timescale 1ns / 1ps
package vpv_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int NUM_REGS      = 8;
  localparam int IDX_W         = 4;
  localparam int QW            = 32 + FRAC_BITS;  // dividend and quotient width
  localparam int NUM_CELLS     = QW;
  localparam int PROD_SH_W     = 64 - FRAC_BITS;
  localparam int SUM_W         = PROD_SH_W + 2;

  localparam logic [63:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic               status;
  } pixel_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cw;
  } clip_t;

  typedef struct packed {
    logic [31:0]   rem;
    logic [QW-1:0] numq;
  } div_lane_t;

  typedef struct packed {
    logic        valid;
    logic        singular;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] dvs;
    div_lane_t   lx;
    div_lane_t   ly;
  } cell_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// File: rtl/vpv_xform.sv
// Matrix-vector stage: nine products, then floor shift, sum and saturation of three clip rows.
`timescale 1ns / 1ps
module vpv_xform (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  vpv_pkg::vertex_t       vtx,
  input  logic [7:0][63:0]       mat,
  output vpv_pkg::clip_t         clip
);

  // Rows 0, 1 and 3 are used; row 2 (clip z) plays no part in the result.
  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] bias_r [3];
  logic               vld_r;
  vpv_pkg::clip_t     clip_r;

  function automatic logic signed [31:0] ent(input logic [7:0][63:0] m,
                                             input int row, input int col);
    logic [63:0] rg;
    rg = m[3'(row * 2 + col / 2)];
    return (col % 2 == 1) ? rg[63:32] : rg[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= ent(mat, (i == 2) ? 3 : i, 0) * vtx.vertex_x;
        prod_r[i][1] <= ent(mat, (i == 2) ? 3 : i, 1) * vtx.vertex_y;
        prod_r[i][2] <= ent(mat, (i == 2) ? 3 : i, 2) * vtx.vertex_z;
        bias_r[i]    <= ent(mat, (i == 2) ? 3 : i, 3);
      end
    end
  end

  logic signed [31:0] row_sat [3];

  always_comb begin
    logic signed [vpv_pkg::SUM_W-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = vpv_pkg::SUM_W'(bias_r[i]);
      for (int j = 0; j < 3; j++) begin
        acc = acc + vpv_pkg::SUM_W'(prod_r[i][j] >>> vpv_pkg::FRAC_BITS);
      end
      row_sat[i] = vpv_pkg::sat32(64'(acc));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.valid <= 1'b0;
    end else if (en) begin
      clip_r.valid <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r.cx <= row_sat[0];
      clip_r.cy <= row_sat[1];
      clip_r.cw <= row_sat[2];
    end
  end

  assign clip = clip_r;

endmodule

// File: rtl/vpv_div_cell.sv
// One restoring-division cell: settles one quotient bit for both the x and y lanes.
`timescale 1ns / 1ps
module vpv_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  vpv_pkg::cell_t  din,
  output vpv_pkg::cell_t  dout
);

  vpv_pkg::cell_t dout_r;
  vpv_pkg::cell_t cell_nxt;

  function automatic vpv_pkg::div_lane_t step(input vpv_pkg::div_lane_t l,
                                              input logic [31:0] d);
    vpv_pkg::div_lane_t o;
    logic [32:0] trial;
    logic        ge;
    trial  = {l.rem, l.numq[vpv_pkg::QW-1]};
    ge     = trial >= {1'b0, d};
    o.rem  = ge ? 32'(trial - {1'b0, d}) : trial[31:0];
    o.numq = {l.numq[vpv_pkg::QW-2:0], ge};
    return o;
  endfunction

  always_comb begin
    cell_nxt    = din;
    cell_nxt.lx = step(din.lx, din.dvs);
    cell_nxt.ly = step(din.ly, din.dvs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else if (en) begin
      dout_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r.singular <= cell_nxt.singular;
      dout_r.neg_x    <= cell_nxt.neg_x;
      dout_r.neg_y    <= cell_nxt.neg_y;
      dout_r.dvs      <= cell_nxt.dvs;
      dout_r.lx       <= cell_nxt.lx;
      dout_r.ly       <= cell_nxt.ly;
    end
  end

  assign dout = dout_r;

endmodule

// File: rtl/vertex_project_viewport_core.sv
// Top level: vertex transform, perspective divide chain and viewport mapping.
`timescale 1ns / 1ps
// Usage.
// The input channel takes one vertex word (x, y, z, signed Q16.16) whenever
// in_valid is high and in_stall is low. Each word yields exactly one result
// word on the output channel, taken when out_valid is high and out_stall low.
// The matrix is loaded through the cfg_ channel, two entries per 64-bit
// register; cfg_ready is always high and writes above index 7 are dropped.
// Throughput is one vertex per cycle while the output is not stalled. The
// registers are the nine products, the row sums, one per quotient bit in
// the chain of 48 division cells, and the viewport mapping into the output
// register. The division chain sets the latency.
// The whole pipeline advances together; it holds only while a result sits in
// the output register and the receiver stalls, in which case in_stall is
// raised in the same cycle and nothing inside moves.
// A zero clip w gives status 1 and zero coordinates.
// Reset (synchronous, active low) empties the pipeline and restores the
// identity matrix.
module vertex_project_viewport_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  vpv_pkg::vertex_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output vpv_pkg::pixel_t                    out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vpv_pkg::IDX_W-1:0]          cfg_index,
  input  logic [63:0]                        cfg_data
);

  logic [7:0][63:0] mat_r;
  logic             en;

  // The user must send configuration only while the pipeline is empty; the
  // block does not enforce it. Registers feed the product stage directly.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vpv_pkg::NUM_REGS; i++) begin
        mat_r[3'(i)] <= vpv_pkg::REG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < vpv_pkg::IDX_W'(vpv_pkg::NUM_REGS)) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // The pipeline moves unless a finished word is being held back.
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  vpv_pkg::clip_t clip;

  vpv_xform u_xform (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid && !in_stall),
    .vtx    (in_data),
    .mat    (mat_r),
    .clip   (clip)
  );

  // Load the division chain with magnitudes; signs travel alongside. The
  // dividend is |clip| shifted up by the fraction width.
  vpv_pkg::cell_t chain [vpv_pkg::NUM_CELLS+1];

  always_comb begin
    chain[0].valid    = clip.valid;
    chain[0].singular = (clip.cw == 32'sd0);
    chain[0].neg_x    = clip.cx[31] ^ clip.cw[31];
    chain[0].neg_y    = clip.cy[31] ^ clip.cw[31];
    chain[0].dvs      = vpv_pkg::mag32(clip.cw);
    chain[0].lx.rem   = '0;
    chain[0].ly.rem   = '0;
    chain[0].lx.numq  = {vpv_pkg::mag32(clip.cx), vpv_pkg::FRAC_BITS'(0)};
    chain[0].ly.numq  = {vpv_pkg::mag32(clip.cy), vpv_pkg::FRAC_BITS'(0)};
  end

  for (genvar g = 0; g < vpv_pkg::NUM_CELLS; g++) begin : g_cell
    vpv_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .din   (chain[g]),
      .dout  (chain[g+1])
    );
  end

  // Quotient to signed, truncated toward zero and saturated.
  function automatic logic signed [31:0] sgn_sat(input logic [vpv_pkg::QW-1:0] q,
                                                 input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = (q > vpv_pkg::QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
    end else begin
      r = (q > vpv_pkg::QW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : 32'(-q[31:0]);
    end
    return r;
  endfunction

  // Viewport: floor(v * size / 2), saturated.
  function automatic logic signed [31:0] vp_map(input logic signed [32:0] v,
                                                input int size);
    logic signed [48:0] p;
    p = 49'(v) * 49'(size);
    return vpv_pkg::sat32(64'(p >>> 1));
  endfunction

  vpv_pkg::cell_t     last;
  logic signed [31:0] nx;
  logic signed [31:0] ny;
  vpv_pkg::pixel_t    res_nxt;
  vpv_pkg::pixel_t    out_data_r;

  assign last = chain[vpv_pkg::NUM_CELLS];

  always_comb begin
    nx = sgn_sat(last.lx.numq, last.neg_x);
    ny = sgn_sat(last.ly.numq, last.neg_y);
    if (last.singular) begin
      res_nxt.pixel_x = '0;
      res_nxt.pixel_y = '0;
      res_nxt.status  = 1'b1;
    end else begin
      res_nxt.pixel_x = vp_map(33'(nx) + (33'sd1 <<< vpv_pkg::FRAC_BITS),
                               vpv_pkg::SCREEN_WIDTH);
      res_nxt.pixel_y = vp_map((33'sd1 <<< vpv_pkg::FRAC_BITS) - 33'(ny),
                               vpv_pkg::SCREEN_HEIGHT);
      res_nxt.status  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/vpv_checker.sv
// Port-level checker for the vertex projection block, bound to the top level.
`timescale 1ns / 1ps
module vpv_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input vpv_pkg::pixel_t out_data
);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or vanished");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a held output word");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.pixel_x == 32'sd0 &&
                                     out_data.pixel_y == 32'sd0)
    else $error("singular result carries nonzero coordinates");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind vertex_project_viewport_core vpv_checker u_vpv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_top.sv
// Testbench for the vertex projection and viewport mapping block.
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY = 51;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vpv_pkg::vertex_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vpv_pkg::pixel_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vpv_pkg::IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  vertex_project_viewport_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The testbench's own copy of the matrix registers.
  logic [63:0] matrix_regs [vpv_pkg::NUM_REGS];
  vpv_pkg::pixel_t pending_pixels [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint entry_of(int row, int col);
    logic [63:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  // Rounds toward minus infinity; >>> on a signed longint does just that.
  function automatic longint floor_shift(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_of(int row, longint x, longint y, longint z);
    longint acc;
    acc = entry_of(row, 3);
    acc += floor_shift(entry_of(row, 0) * x, vpv_pkg::FRAC_BITS);
    acc += floor_shift(entry_of(row, 1) * y, vpv_pkg::FRAC_BITS);
    acc += floor_shift(entry_of(row, 2) * z, vpv_pkg::FRAC_BITS);
    return clamp32(acc);
  endfunction

  function automatic vpv_pkg::pixel_t project_vertex(vpv_pkg::vertex_t v);
    vpv_pkg::pixel_t p;
    longint cx, cy, cw, nx, ny, one;
    one = longint'(1) << vpv_pkg::FRAC_BITS;
    cx = clip_of(0, v.vertex_x, v.vertex_y, v.vertex_z);
    cy = clip_of(1, v.vertex_x, v.vertex_y, v.vertex_z);
    cw = clip_of(3, v.vertex_x, v.vertex_y, v.vertex_z);
    p = '0;
    if (cw == 0) begin
      p.status = 1'b1;
      return p;
    end
    // SystemVerilog division on signed operands truncates toward zero.
    nx = clamp32((cx * one) / cw);
    ny = clamp32((cy * one) / cw);
    p.pixel_x = 32'(clamp32(floor_shift((nx + one) * vpv_pkg::SCREEN_WIDTH, 1)));
    p.pixel_y = 32'(clamp32(floor_shift((one - ny) * vpv_pkg::SCREEN_HEIGHT, 1)));
    return p;
  endfunction

  // Sends one vertex word, with a random gap before it. The valid stays up
  // after acceptance so that a following word can go out back to back.
  task automatic send_vertex(vpv_pkg::vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(project_vertex(v));
  endtask

  // Receiver side: random stall, and each accepted word checked in order.
  always @(posedge clk) begin
    vpv_pkg::pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, want.pixel_x,
                   out_data.pixel_x);
          errors++;
        end
        if (out_data.pixel_y !== want.pixel_y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, want.pixel_y,
                   out_data.pixel_y);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Configuration writes happen only with the pipeline empty. The valid
  // stays up after the write; the caller drops it after its last write.
  task automatic write_reg(int idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= vpv_pkg::IDX_W'(idx);
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < vpv_pkg::NUM_REGS) matrix_regs[idx] = value;
  endtask

  task automatic load_matrix(logic [63:0] regs [vpv_pkg::NUM_REGS]);
    wait_drained();
    for (int i = 0; i < vpv_pkg::NUM_REGS; i++) write_reg(i, regs[i]);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(6))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      3: return 32'h0;
      default: return 32'($signed($urandom_range(4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic vpv_pkg::vertex_t rand_vertex();
    vpv_pkg::vertex_t v;
    v.vertex_x = rand_coord();
    v.vertex_y = rand_coord();
    v.vertex_z = rand_coord();
    return v;
  endfunction

  // Identity matrix: extreme and small coordinates, with w held at 1.0.
  task automatic test_directed_identity();
    vpv_pkg::vertex_t v;
    logic [31:0] pts [6] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
    for (int i = 0; i < 6; i++) begin
      v.vertex_x = pts[i];
      v.vertex_y = pts[5 - i];
      v.vertex_z = pts[(i + 2) % 6];
      send_vertex(v);
    end
  endtask

  // Perspective matrix with w = floor(z / 2^16), so z near zero gives a
  // singular result and a tiny z truncates w to zero.
  task automatic test_directed_perspective();
    logic [63:0] regs [vpv_pkg::NUM_REGS];
    vpv_pkg::vertex_t v;
    regs = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
             64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0000_0000_0000_0001};
    load_matrix(regs);
    v = '{32'h0001_0000, 32'h0002_0000, 32'h0};
    send_vertex(v);
    v = '{32'h0001_0000, 32'h0001_0000, 32'h0000_0001};
    send_vertex(v);
    v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    send_vertex(v);
    v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_vertex(v);
    v = '{32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000};
    send_vertex(v);
    regs = '{64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF,
             64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000};
    load_matrix(regs);
    for (int i = 0; i < 6; i++) send_vertex(rand_vertex());
    // An index above the last register must be ignored.
    wait_drained();
    write_reg(8, 64'hDEAD_BEEF_DEAD_BEEF);
    write_reg(15, 64'h0);
    cfg_valid <= 1'b0;
    send_vertex(rand_vertex());
  endtask

  // Random matrices in phases, random vertices in each.
  task automatic test_random(int count);
    logic [63:0] regs [vpv_pkg::NUM_REGS];
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        for (int i = 0; i < vpv_pkg::NUM_REGS; i++) regs[i] = {rand_entry(), rand_entry()};
        // Mostly a w row that keeps w away from zero, sometimes a bare one.
        if ($urandom_range(3) != 0) regs[7][63:32] = 32'h0001_0000 + $urandom_range(1 << 18);
        if ($urandom_range(7) == 0) begin
          regs[6] = '0;
          regs[7] = '0;
        end
        load_matrix(regs);
      end
      send_vertex(rand_vertex());
    end
  endtask

  initial begin
    for (int i = 0; i < vpv_pkg::NUM_REGS; i++) matrix_regs[i] = vpv_pkg::REG_RESET[i];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 11;
    recv_stall_pct = 81;
    test_directed_identity();
    test_directed_perspective();
    test_random(600);
    send_idle_pct = 81;
    recv_stall_pct = 11;
    test_random(600);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(700);
    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
rtl/vpv_pkg.sv
rtl/vpv_xform.sv
rtl/vpv_div_cell.sv
rtl/vertex_project_viewport_core.sv
rtl/vpv_checker.sv
sim/tb_top.sv
